// ===== design/ipse_pkg.sv =====
// Shared types and constants for the indexed stack engine.
package ipse_pkg;

  localparam int IPSE_DEPTH = 256;
  localparam int TAG_W      = 8;
  localparam int VAL_W      = 64;
  localparam int IDX_W      = 16;
  localparam int CAP_W      = 9;
  localparam int OUT_W      = 9;
  localparam int MODE_W     = 4;
  localparam int STAT_W     = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    M_PUSH      = 4'd0,
    M_PUSH_COPY = 4'd1,
    M_POP       = 4'd2,
    M_POP_N     = 4'd3,
    M_SET_TOP   = 4'd4,
    M_INSERT    = 4'd5,
    M_REMOVE    = 4'd6,
    M_REPLACE   = 4'd7,
    M_COPY      = 4'd8,
    M_ROTATE    = 4'd9,
    M_SWAP      = 4'd10,
    M_READ      = 4'd11,
    M_CLEAR     = 4'd12
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_IDX  = 3'd3,
    ST_BAD_IDX2 = 3'd4,
    ST_FEW      = 3'd5
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [IDX_W-1:0] index;
    logic signed [IDX_W-1:0] index_second;
    logic signed [IDX_W-1:0] rotate_count;
    logic [IDX_W-1:0]        pop_count;
    entry_t                  entry;
  } req_t;

  // Memory port controls between the sequencer and the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== design/ipse_if.sv =====
// Request and result channel interfaces of the indexed stack engine.
interface ipse_req_if;
  import ipse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic signed [IDX_W-1:0] index;
  logic signed [IDX_W-1:0] index_second;
  logic signed [IDX_W-1:0] rotate_count;
  logic [IDX_W-1:0]        pop_count;
  logic [TAG_W-1:0]        entry_tag;
  logic [VAL_W-1:0]        entry_value;

  modport source (output valid, mode, index, index_second, rotate_count, pop_count,
                  entry_tag, entry_value, input ready);
  modport sink   (input valid, mode, index, index_second, rotate_count, pop_count,
                  entry_tag, entry_value, output ready);
endinterface

interface ipse_rsp_if;
  import ipse_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  out_tag;
  logic [VAL_W-1:0]  out_value;
  logic [OUT_W-1:0]  depth;
  logic [OUT_W-1:0]  abs_position;

  modport source (output valid, status, out_tag, out_value, depth, abs_position,
                  input ready);
  modport sink   (input valid, status, out_tag, out_value, depth, abs_position,
                  output ready);
endinterface

// ===== design/ipse_mem.sv =====
// Entry store: one write port and one registered read port.
module ipse_mem #(
  parameter int DEPTH  = ipse_pkg::IPSE_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  ipse_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ipse_pkg::entry_t     wr_data,
  output ipse_pkg::entry_t     rd_data
);
  import ipse_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ipse_mod.sv =====
// Restoring remainder unit: one dividend bit per cycle.
module ipse_mod #(
  parameter int DIV_W = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ipse_pkg::IDX_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [DIV_W-1:0]           remainder
);
  import ipse_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[IDX_W-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(IDX_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      dvd_nxt = {dvd_r[IDX_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== design/indexed_param_stack_engine_top.sv =====
// Top level of the indexed stack engine: sequencer around the entry store.
//
//   Channel  Direction  Handshake          Contents
//   in_req   in         valid/ready        one operation request
//   out_rsp  out        valid/ready        status, entry, depth, position
//   cfg      in         cfg_we/cfg_wdata   stack capacity
//
// One request is worked at a time. Push, pop_n, set_top and clear finish in the
// evaluation state; pop, read, push_copy, replace and copy add a read and a
// transfer state, and swap a pair swap, all through the single read and write
// port of the store. Insert, remove and rotate wait for the remainder unit and,
// for a non-zero rotation, reverse three segments, each with a check state and
// a swap of reads and writes per pair. A pending result does not block the
// next request; a new result waits in its final state until the output register
// is free. No clearing pass follows reset.
module indexed_param_stack_engine_top #(
  parameter int DEPTH = ipse_pkg::IPSE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ipse_req_if.sink                   in_req,
  ipse_rsp_if.source                 out_rsp,
  input  logic                       cfg_we,
  input  logic [ipse_pkg::CAP_W-1:0] cfg_wdata
);
  import ipse_pkg::*;

  localparam int PTR_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int S_W = 18;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_EVAL = 11'b00000000010,
    S_RD   = 11'b00000000100,
    S_XF   = 11'b00000001000,
    S_MOD  = 11'b00000010000,
    S_CHK  = 11'b00000100000,
    S_RA   = 11'b00001000000,
    S_RB   = 11'b00010000000,
    S_WA   = 11'b00100000000,
    S_WB   = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_ALL  = 2'd0,
    PH_HEAD = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  req_t              req_r, req_nxt;
  logic [PTR_W-1:0]  top_r, top_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  status_t           status_r, status_nxt;
  entry_t            ret_r, ret_nxt;
  entry_t            hold_r, hold_nxt;
  logic [PTR_W-1:0]  absp_r, absp_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic              wback_r, wback_nxt;
  logic              capt_r, capt_nxt;
  logic              neg_r, neg_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [PTR_W-1:0]  cnt_r, cnt_nxt;
  logic [PTR_W-1:0]  rot_r, rot_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  entry_t            out_entry_r, out_entry_nxt;
  logic [OUT_W-1:0]  out_depth_r, out_depth_nxt;
  logic [OUT_W-1:0]  out_absp_r, out_absp_nxt;

  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
  entry_t            mem_wr_data, mem_rd_data;

  logic              mod_start, mod_done;
  logic [IDX_W-1:0]  mod_dvd;
  logic [PTR_W-1:0]  mod_dsr, mod_rem, rot_amt;

  logic signed [S_W-1:0] top_s, pos_a, pos_b, set_r, popn_r;
  logic                  val_a, val_b, full;
  logic [ADDR_W-1:0]     slot_a, slot_b, slot_top1, slot_top2;
  logic [PTR_W-1:0]      seg_cnt;
  logic                  in_acc, out_free;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  // Index resolution against the current depth.
  always_comb begin
    top_s  = signed'(S_W'(top_r));
    pos_a  = (req_r.index > 0) ? S_W'(req_r.index)
                               : top_s + S_W'(req_r.index) + S_W'(1);
    pos_b  = (req_r.index_second > 0) ? S_W'(req_r.index_second)
                                      : top_s + S_W'(req_r.index_second) + S_W'(1);
    val_a  = (top_r != '0) && (req_r.index != '0) && (pos_a >= S_W'(1))
             && (pos_a <= top_s);
    val_b  = (top_r != '0) && (req_r.index_second != '0) && (pos_b >= S_W'(1))
             && (pos_b <= top_s);
    slot_a = ADDR_W'(pos_a - S_W'(1));
    slot_b = ADDR_W'(pos_b - S_W'(1));
    slot_top1 = ADDR_W'(top_s - S_W'(1));
    slot_top2 = ADDR_W'(top_s - S_W'(2));
    seg_cnt   = PTR_W'(top_s - pos_a + S_W'(1));
    full   = (top_s >= signed'(S_W'(cap_r))) || (top_s >= S_W'(DEPTH));
    set_r  = top_s + S_W'(req_r.index) + S_W'(1);
    popn_r = top_s - signed'(S_W'(req_r.pop_count));
    rot_amt = (neg_r && (mod_rem != '0)) ? cnt_r - mod_rem : mod_rem;
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    req_nxt     = req_r;
    top_nxt     = top_r;
    cap_nxt     = cfg_we ? cfg_wdata : cap_r;
    status_nxt  = status_r;
    ret_nxt     = ret_r;
    hold_nxt    = hold_r;
    absp_nxt    = absp_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    wback_nxt   = wback_r;
    capt_nxt    = capt_r;
    neg_nxt     = neg_r;
    lo_nxt      = lo_r;
    cnt_nxt     = cnt_r;
    rot_nxt     = rot_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_depth_nxt  = out_depth_r;
    out_absp_nxt   = out_absp_r;
    mem_ctl     = '0;
    mem_rd_addr = src_r;
    mem_wr_addr = dst_r;
    mem_wr_data = mem_rd_data;
    mod_start   = 1'b0;
    mod_dvd     = '0;
    mod_dsr     = seg_cnt;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt.mode         = mode_t'(in_req.mode);
          req_nxt.index        = in_req.index;
          req_nxt.index_second = in_req.index_second;
          req_nxt.rotate_count = in_req.rotate_count;
          req_nxt.pop_count    = in_req.pop_count;
          req_nxt.entry.tag    = in_req.entry_tag;
          req_nxt.entry.value  = in_req.entry_value;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        status_nxt = ST_OK;
        ret_nxt    = '0;
        absp_nxt   = '0;
        wback_nxt  = 1'b0;
        capt_nxt   = 1'b0;
        state_nxt  = S_DONE;
        case (req_r.mode)
          M_PUSH: begin
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              mem_ctl.wr_en = 1'b1;
              mem_wr_addr   = ADDR_W'(top_r);
              mem_wr_data   = req_r.entry;
              top_nxt       = top_r + PTR_W'(1);
            end
          end
          M_PUSH_COPY: begin
            if (!val_a) begin
              status_nxt = ST_BAD_IDX;
            end else if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              src_nxt   = slot_a;
              dst_nxt   = ADDR_W'(top_r);
              wback_nxt = 1'b1;
              top_nxt   = top_r + PTR_W'(1);
              state_nxt = S_RD;
            end
          end
          M_POP: begin
            if (top_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              src_nxt   = slot_top1;
              capt_nxt  = 1'b1;
              top_nxt   = top_r - PTR_W'(1);
              state_nxt = S_RD;
            end
          end
          M_POP_N: begin
            top_nxt = (popn_r < 0) ? '0 : PTR_W'(popn_r);
          end
          M_SET_TOP: begin
            if (req_r.index >= 0) begin
              if (S_W'(req_r.index) < top_s) begin
                top_nxt = PTR_W'(req_r.index);
              end
            end else begin
              top_nxt = (set_r < 0) ? '0 : PTR_W'(set_r);
            end
          end
          M_INSERT, M_REMOVE, M_ROTATE: begin
            if (top_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (!val_a) begin
              status_nxt = ST_BAD_IDX;
            end else begin
              // Insert and remove are rotations of the segment by one place.
              lo_nxt    = slot_a;
              cnt_nxt   = seg_cnt;
              mod_start = 1'b1;
              if (req_r.mode == M_ROTATE) begin
                neg_nxt = req_r.rotate_count < 0;
                mod_dvd = (req_r.rotate_count < 0) ? IDX_W'(-req_r.rotate_count)
                                                   : IDX_W'(req_r.rotate_count);
              end else begin
                neg_nxt = (req_r.mode == M_REMOVE);
                mod_dvd = IDX_W'(1);
              end
              if (req_r.mode == M_REMOVE) begin
                top_nxt = top_r - PTR_W'(1);
              end
              state_nxt = S_MOD;
            end
          end
          M_REPLACE: begin
            if (top_r == '0) begin
              status_nxt = ST_EMPTY;
            end else if (!val_a) begin
              status_nxt = ST_BAD_IDX;
            end else begin
              src_nxt   = slot_top1;
              dst_nxt   = slot_a;
              wback_nxt = 1'b1;
              top_nxt   = top_r - PTR_W'(1);
              state_nxt = S_RD;
            end
          end
          M_COPY: begin
            if (!val_a) begin
              status_nxt = ST_BAD_IDX;
            end else if (!val_b) begin
              status_nxt = ST_BAD_IDX2;
            end else begin
              src_nxt   = slot_a;
              dst_nxt   = slot_b;
              wback_nxt = 1'b1;
              state_nxt = S_RD;
            end
          end
          M_SWAP: begin
            if (top_r < PTR_W'(2)) begin
              status_nxt = ST_FEW;
            end else begin
              phase_nxt = PH_TAIL;
              i_nxt     = slot_top2;
              j_nxt     = slot_top1;
              state_nxt = S_CHK;
            end
          end
          M_READ: begin
            if (!val_a) begin
              status_nxt = ST_BAD_IDX;
            end else begin
              src_nxt   = slot_a;
              capt_nxt  = 1'b1;
              absp_nxt  = PTR_W'(pos_a);
              state_nxt = S_RD;
            end
          end
          M_CLEAR: begin
            top_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = S_XF;
      end
      S_XF: begin
        mem_ctl.wr_en = wback_r;
        if (capt_r) begin
          ret_nxt = mem_rd_data;
        end
        state_nxt = S_DONE;
      end
      S_MOD: begin
        if (mod_done) begin
          rot_nxt = rot_amt;
          if (rot_amt == '0) begin
            state_nxt = S_DONE;
          end else begin
            // Right rotation: reverse all, then the head of rot_amt, then the rest.
            phase_nxt = PH_ALL;
            i_nxt     = lo_r;
            j_nxt     = ADDR_W'({1'b0, lo_r} + (PTR_W + 1)'(cnt_r) - (PTR_W + 1)'(1));
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (i_r < j_r) begin
          state_nxt = S_RA;
        end else begin
          unique case (phase_r)
            PH_ALL: begin
              phase_nxt = PH_HEAD;
              i_nxt     = lo_r;
              j_nxt     = ADDR_W'({1'b0, lo_r} + (PTR_W + 1)'(rot_r) - (PTR_W + 1)'(1));
            end
            PH_HEAD: begin
              phase_nxt = PH_TAIL;
              i_nxt     = ADDR_W'({1'b0, lo_r} + (PTR_W + 1)'(rot_r));
              j_nxt     = ADDR_W'({1'b0, lo_r} + (PTR_W + 1)'(cnt_r) - (PTR_W + 1)'(1));
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RA: begin
        mem_ctl.rd_en = 1'b1;
        mem_rd_addr   = i_r;
        state_nxt     = S_RB;
      end
      S_RB: begin
        mem_ctl.rd_en = 1'b1;
        mem_rd_addr   = j_r;
        hold_nxt      = mem_rd_data;
        state_nxt     = S_WA;
      end
      S_WA: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_addr   = i_r;
        mem_wr_data   = mem_rd_data;
        state_nxt     = S_WB;
      end
      S_WB: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_addr   = j_r;
        mem_wr_data   = hold_r;
        i_nxt         = i_r + ADDR_W'(1);
        j_nxt         = j_r - ADDR_W'(1);
        state_nxt     = S_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_entry_nxt  = ret_r;
          out_depth_nxt  = OUT_W'(top_r);
          out_absp_nxt   = OUT_W'(absp_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_ALL;
      top_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      top_r       <= top_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    status_r     <= status_nxt;
    ret_r        <= ret_nxt;
    hold_r       <= hold_nxt;
    absp_r       <= absp_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    wback_r      <= wback_nxt;
    capt_r       <= capt_nxt;
    neg_r        <= neg_nxt;
    lo_r         <= lo_nxt;
    cnt_r        <= cnt_nxt;
    rot_r        <= rot_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_depth_r  <= out_depth_nxt;
    out_absp_r   <= out_absp_nxt;
  end

  ipse_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  ipse_mod #(
    .DIV_W (PTR_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dvd),
    .divisor   (mod_dsr),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.out_tag      = out_entry_r.tag;
  assign out_rsp.out_value    = out_entry_r.value;
  assign out_rsp.depth        = out_depth_r;
  assign out_rsp.abs_position = out_absp_r;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= PTR_W'(DEPTH))
    else $error("stack depth beyond the store size");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !mem_ctl.wr_en)
    else $error("store written while waiting for a request");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EVAL))
    else $error("accepted request not evaluated next cycle");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder finished outside its wait state");
`endif

endmodule

// ===== verif/indexed_param_stack_engine_top_test.sv =====
// Self-checking testbench for the indexed stack engine: directed and random requests against a stack model.
module indexed_param_stack_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ipse_pkg::*;

  localparam int LIMIT = 20000000;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [IDX_W-1:0] index;
    logic signed [IDX_W-1:0] index_second;
    logic signed [IDX_W-1:0] rotate_count;
    logic [IDX_W-1:0]        pop_count;
    logic [TAG_W-1:0]        tag;
    logic [VAL_W-1:0]        value;
  } op_req_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic [VAL_W-1:0]  value;
    logic [OUT_W-1:0]  depth;
    logic [OUT_W-1:0]  abs_pos;
  } op_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  ipse_req_if in_req();
  ipse_rsp_if out_rsp();

  indexed_param_stack_engine_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Stack model
  entry_t stack_mem [IPSE_DEPTH];
  int     stack_depth = 0;
  int     stack_cap = 256;

  op_req_t pending_reqs[$];
  op_rsp_t expected_rsps[$];
  bit      failed = 1'b0;
  bit      no_idle = 1'b0;
  int      req_gap = 0;
  int      rsp_stall = 0;
  logic    req_taken = 1'b0;
  logic    rsp_taken = 1'b0;
  int      cycles = 0;

  function automatic int resolve_index(int idx);
    int pos;
    if (stack_depth == 0 || idx == 0) return -1;
    pos = (idx > 0) ? idx : stack_depth + idx + 1;
    if (pos < 1 || pos > stack_depth) return -1;
    return pos - 1;
  endfunction

  function automatic logic [STAT_W-1:0] push_entry(entry_t e);
    int lim;
    lim = (stack_cap < IPSE_DEPTH) ? stack_cap : IPSE_DEPTH;
    if (stack_depth >= lim) return ST_OVERFLOW;
    stack_mem[stack_depth] = e;
    stack_depth++;
    return ST_OK;
  endfunction

  function automatic op_rsp_t apply_op(op_req_t q);
    op_rsp_t r;
    entry_t  t;
    entry_t  tmp [IPSE_DEPTH];
    int a, b, i, cnt, rot, idx;
    r.status = ST_OK; r.tag = '0; r.value = '0; r.abs_pos = '0;
    idx = q.index;
    case (q.mode)
      M_PUSH: begin
        t.tag = q.tag; t.value = q.value;
        r.status = push_entry(t);
      end
      M_PUSH_COPY: begin
        a = resolve_index(idx);
        if (a < 0) r.status = ST_BAD_IDX;
        else r.status = push_entry(stack_mem[a]);
      end
      M_POP: begin
        if (stack_depth == 0) r.status = ST_EMPTY;
        else begin
          stack_depth--;
          r.tag = stack_mem[stack_depth].tag;
          r.value = stack_mem[stack_depth].value;
        end
      end
      M_POP_N: stack_depth = (int'(q.pop_count) > stack_depth) ? 0
                             : stack_depth - int'(q.pop_count);
      M_SET_TOP: begin
        if (idx >= 0) begin
          if (idx < stack_depth) stack_depth = idx;
        end else begin
          a = stack_depth + idx + 1;
          stack_depth = (a < 0) ? 0 : a;
        end
      end
      M_INSERT, M_REMOVE, M_REPLACE, M_ROTATE: begin
        a = resolve_index(idx);
        if (stack_depth == 0) r.status = ST_EMPTY;
        else if (a < 0) r.status = ST_BAD_IDX;
        else if (q.mode == M_INSERT) begin
          t = stack_mem[stack_depth-1];
          for (i = stack_depth - 1; i > a; i--) stack_mem[i] = stack_mem[i-1];
          stack_mem[a] = t;
        end else if (q.mode == M_REMOVE) begin
          for (i = a; i < stack_depth - 1; i++) stack_mem[i] = stack_mem[i+1];
          stack_depth--;
        end else if (q.mode == M_REPLACE) begin
          stack_mem[a] = stack_mem[stack_depth-1];
          stack_depth--;
        end else begin
          cnt = stack_depth - a;
          rot = q.rotate_count;
          if (cnt > 1) begin
            rot = rot % cnt;
            if (rot < 0) rot += cnt;
            for (i = 0; i < cnt; i++) tmp[(i + rot) % cnt] = stack_mem[a+i];
            for (i = 0; i < cnt; i++) stack_mem[a+i] = tmp[i];
          end
        end
      end
      M_COPY: begin
        a = resolve_index(idx);
        b = resolve_index(int'(q.index_second));
        if (a < 0) r.status = ST_BAD_IDX;
        else if (b < 0) r.status = ST_BAD_IDX2;
        else stack_mem[b] = stack_mem[a];
      end
      M_SWAP: begin
        if (stack_depth < 2) r.status = ST_FEW;
        else begin
          t = stack_mem[stack_depth-1];
          stack_mem[stack_depth-1] = stack_mem[stack_depth-2];
          stack_mem[stack_depth-2] = t;
        end
      end
      M_READ: begin
        a = resolve_index(idx);
        if (a < 0) r.status = ST_BAD_IDX;
        else begin
          r.tag = stack_mem[a].tag;
          r.value = stack_mem[a].value;
          r.abs_pos = OUT_W'(a + 1);
        end
      end
      M_CLEAR: stack_depth = 0;
      default: ;
    endcase
    r.depth = stack_depth[OUT_W-1:0];
    return r;
  endfunction

  function automatic op_req_t make_req(logic [MODE_W-1:0] m, int idx, int idx2, int rot,
                                       int pc, logic [TAG_W-1:0] tg, logic [VAL_W-1:0] v);
    op_req_t q;
    q.mode = m; q.index = idx[IDX_W-1:0]; q.index_second = idx2[IDX_W-1:0];
    q.rotate_count = rot[IDX_W-1:0]; q.pop_count = pc[IDX_W-1:0];
    q.tag = tg; q.value = v;
    return q;
  endfunction

  // Mostly indices near the occupied range, now and then any 16-bit value.
  function automatic int pick_index();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return int'($signed($urandom_range(0, 65535) - 0) << 16) >>> 16;
    if (m < 5) return $urandom_range(1, 48);
    return -int'($urandom_range(1, 48));
  endfunction

  function automatic op_req_t random_req(int push_w);
    int sel;
    logic [MODE_W-1:0] m;
    sel = $urandom_range(0, 99);
    if (sel < push_w) m = M_PUSH;
    else if (sel < push_w + 3) m = MODE_W'($urandom_range(13, 15));
    else m = MODE_W'($urandom_range(1, 12));
    // Keep clears and large drops rare so the stack builds up.
    if ((m == M_CLEAR || m == M_POP_N || m == M_SET_TOP) && $urandom_range(0, 2) != 0)
      m = M_READ;
    return make_req(m, pick_index(), pick_index(),
                    ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(0, 20)) - 10,
                    ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535))
                                                : int'($urandom_range(0, 4)),
                    TAG_W'($urandom_range(0, 255)), {$urandom(), $urandom()});
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || req_taken) begin
      if (req_gap > 0) begin
        in_req.valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        in_req.valid        <= 1'b1;
        in_req.mode         <= pending_reqs[0].mode;
        in_req.index        <= pending_reqs[0].index;
        in_req.index_second <= pending_reqs[0].index_second;
        in_req.rotate_count <= pending_reqs[0].rotate_count;
        in_req.pop_count    <= pending_reqs[0].pop_count;
        in_req.entry_tag    <= pending_reqs[0].tag;
        in_req.entry_value  <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
        req_gap <= no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (rsp_taken && !no_idle && rsp_stall == 0) begin
      rsp_stall = $urandom_range(0, 3);
      out_rsp.ready <= (rsp_stall == 0);
    end else if (rsp_stall > 0) begin
      rsp_stall = rsp_stall - 1;
      out_rsp.ready <= (rsp_stall == 0);
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // Accepted requests go through the model; accepted results are checked.
  always @(posedge clk) begin
    op_req_t q;
    op_rsp_t e;
    cycles <= cycles + 1;
    req_taken <= rst_n && in_req.valid && in_req.ready;
    rsp_taken <= rst_n && out_rsp.valid && out_rsp.ready;
    if (rst_n && in_req.valid && in_req.ready) begin
      q = make_req(in_req.mode, in_req.index, in_req.index_second, in_req.rotate_count,
                   in_req.pop_count, in_req.entry_tag, in_req.entry_value);
      expected_rsps.push_back(apply_op(q));
    end
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result: status %0d depth %0d", out_rsp.status, out_rsp.depth);
        failed = 1'b1;
      end else begin
        e = expected_rsps.pop_front();
        if (out_rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_rsp.status);
          failed = 1'b1;
        end
        if (out_rsp.out_tag !== e.tag) begin
          $error("out_tag: expected %0h, got %0h", e.tag, out_rsp.out_tag);
          failed = 1'b1;
        end
        if (out_rsp.out_value !== e.value) begin
          $error("out_value: expected %0h, got %0h", e.value, out_rsp.out_value);
          failed = 1'b1;
        end
        if (out_rsp.depth !== e.depth) begin
          $error("depth: expected %0d, got %0d", e.depth, out_rsp.depth);
          failed = 1'b1;
        end
        if (out_rsp.abs_position !== e.abs_pos) begin
          $error("abs_position: expected %0d, got %0d", e.abs_pos, out_rsp.abs_position);
          failed = 1'b1;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_req.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_capacity(int cap);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap[CAP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    stack_cap = cap;
  endtask

  int caps [7] = '{256, 1, 5, 40, 256, 3, 128};
  int pushw [7] = '{45, 40, 40, 40, 70, 35, 50};

  initial begin
    in_req.valid = 1'b0; in_req.mode = '0; in_req.index = '0; in_req.index_second = '0;
    in_req.rotate_count = '0; in_req.pop_count = '0; in_req.entry_tag = '0;
    in_req.entry_value = '0; out_rsp.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_capacity(4);
    // Empty-stack cases first, then the field extremes and every operation.
    pending_reqs.push_back(make_req(M_POP, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_READ, -1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_INSERT, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_PUSH_COPY, -1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_COPY, 1, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_SWAP, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_PUSH, 0, 0, 0, 0, 8'h00, 64'h0));
    pending_reqs.push_back(make_req(M_SWAP, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_PUSH, 0, 0, 0, 0, 8'hff, '1));
    pending_reqs.push_back(make_req(M_PUSH_COPY, -1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_PUSH, 0, 0, 0, 0, 8'h5a, 64'h0123456789abcdef));
    pending_reqs.push_back(make_req(M_PUSH, 0, 0, 0, 0, 8'h11, 64'h1));
    pending_reqs.push_back(make_req(M_PUSH_COPY, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_READ, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_READ, 32767, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_COPY, -32768, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_COPY, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_ROTATE, 1, 0, 32767, 0, 0, 0));
    pending_reqs.push_back(make_req(M_ROTATE, 2, 0, -32768, 0, 0, 0));
    pending_reqs.push_back(make_req(M_ROTATE, -1, 0, 5, 0, 0, 0));
    pending_reqs.push_back(make_req(M_INSERT, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_REPLACE, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_REMOVE, -2, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(4'd15, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_SET_TOP, 32767, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_SET_TOP, -32768, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(M_POP_N, 0, 0, 0, 65535, 0, 0));
    pending_reqs.push_back(make_req(M_CLEAR, 0, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < 7; p++) begin
      set_capacity(caps[p]);
      no_idle = (p == 3);
      for (int n = 0; n < 250; n++) pending_reqs.push_back(random_req(pushw[p]));
      drain();
    end

    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
